// ===== sv/b32d_pkg.sv =====
package b32d_pkg;

  localparam int unsigned CharW     = 16;
  localparam int unsigned LimitW    = 10;
  localparam int unsigned SymW      = 5;
  localparam int unsigned GroupLen  = 8;
  localparam int unsigned GroupBits = SymW * GroupLen;
  localparam int unsigned QueueDepth = 4;

  localparam logic [LimitW-1:0] LimitReset = 10'd64;
  localparam logic [CharW-1:0]  PadChar    = 16'h003D;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusBadChar = 2'd1,
    StatusLimit   = 2'd2
  } status_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
  } out_t;

  // one unit of work for the back end: up to five bytes of a group
  typedef struct packed {
    logic [GroupBits-1:0] bits;
    logic [2:0]           count;
    logic                 last;
    status_e              status;
  } job_t;

  // returns {not_in_alphabet, symbol value}
  function automatic logic [SymW:0] symbol_value(input logic [CharW-1:0] c);
    logic [SymW:0] r;
    r = {1'b1, {SymW{1'b0}}};
    if (c inside {[16'h0041:16'h005A], [16'h0061:16'h007A]}) begin
      r = {1'b0, c[4:0] - 5'd1};
    end else if (c inside {[16'h0032:16'h0037]}) begin
      r = {1'b0, c[4:0] + 5'd8};
    end
    return r;
  endfunction

endpackage

// ===== sv/base32_decoder.sv =====
// channel   dir  handshake                payload
// cfg       in   cfg_we_i                 cfg_wdata_i (out_limit, 10 bits)
// in        in   in_valid_i / in_ready_o  in_data_i  (char_code, end_of_string)
// out       out  out_valid_o / out_ready_i out_data_o (data_byte, byte_valid, last, status)
//
// one character item is taken every cycle while the job queue has room
// each group of eight symbols becomes a job of five bytes; the back end emits
// one result item per cycle while out_ready_i keeps the output register free
// the character completing a group pushes its job into the queue, and its results pass through the output register
// asynchronous active-low reset clears string state and the queue, and sets out_limit to 64
// a stalled output fills the four-entry queue, then in_ready_o drops
module base32_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [b32d_pkg::LimitW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  b32d_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output b32d_pkg::out_t              out_data_o
);

  // front to queue
  logic           push;
  logic           full;
  b32d_pkg::job_t job_in;

  // queue to back
  logic           pop;
  logic           empty;
  b32d_pkg::job_t job_head;

  // front: classify each character, track the group, decide byte counts
  b32d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job_in)
  );

  // short job queue so a stalled output does not stall the input at once
  b32d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_head),
    .empty_o (empty)
  );

  // back: serialize each job into result items through an output register
  b32d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/b32d_front.sv =====
module b32d_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [b32d_pkg::LimitW-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  b32d_pkg::in_t                    in_data_i,
  input  logic                             full_i,
  output logic                             push_o,
  output b32d_pkg::job_t                   job_o
);

  logic [b32d_pkg::SymW-1:0]   sym_q [b32d_pkg::GroupLen];
  logic [2:0]                  fill_q, fill_d;
  logic                        pad_q, pad_d;
  b32d_pkg::status_e           err_q, err_d;
  logic [b32d_pkg::LimitW-1:0] bytes_q, bytes_d;
  logic [b32d_pkg::LimitW-1:0] limit_q;

  logic                        accept;
  logic [b32d_pkg::SymW:0]     sv_res;
  logic                        wr_sym;
  logic                        full_grp;
  logic [2:0]                  n_out;
  logic [2:0]                  tail_n;
  logic [b32d_pkg::SymW-1:0]   grp_now [b32d_pkg::GroupLen];

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sv_res     = b32d_pkg::symbol_value(in_data_i.char_code);

  always_comb begin
    fill_d   = fill_q;
    pad_d    = pad_q;
    err_d    = err_q;
    bytes_d  = bytes_q;
    wr_sym   = 1'b0;
    full_grp = 1'b0;
    n_out    = 3'd0;
    tail_n   = 3'd0;
    if (err_q == b32d_pkg::StatusOk) begin
      if (in_data_i.char_code == b32d_pkg::PadChar) begin
        pad_d = 1'b1;
      end else if (pad_q) begin
        err_d = b32d_pkg::StatusBadChar;
      end else if (sv_res[b32d_pkg::SymW]) begin
        err_d = b32d_pkg::StatusBadChar;
      end else begin
        wr_sym = 1'b1;
        if (fill_q == 3'd7) begin
          fill_d = 3'd0;
          if ({1'b0, bytes_q} + 11'd5 > {1'b0, limit_q}) begin
            err_d = b32d_pkg::StatusLimit;
          end else begin
            full_grp = 1'b1;
            n_out    = 3'd5;
            bytes_d  = bytes_q + 10'd5;
          end
        end else begin
          fill_d = fill_q + 3'd1;
        end
      end
    end
    // partial group at string end
    if (in_data_i.end_of_string && err_d == b32d_pkg::StatusOk && fill_d != 3'd0) begin
      case (fill_d)
        3'd2:    tail_n = 3'd1;
        3'd4:    tail_n = 3'd2;
        3'd5:    tail_n = 3'd3;
        3'd7:    tail_n = 3'd4;
        default: tail_n = 3'd0;
      endcase
      if (tail_n != 3'd0) begin
        if ({1'b0, bytes_q} + {8'd0, tail_n} > {1'b0, limit_q}) begin
          err_d = b32d_pkg::StatusLimit;
        end else begin
          n_out   = tail_n;
          bytes_d = bytes_q + {7'd0, tail_n};
        end
      end
    end
  end

  // group with the new symbol merged in; tail slots past the fill read as zero
  always_comb begin
    for (int i = 0; i < b32d_pkg::GroupLen; i++) begin
      if (wr_sym && fill_q == 3'(i)) begin
        grp_now[i] = sv_res[b32d_pkg::SymW-1:0];
      end else begin
        grp_now[i] = sym_q[i];
      end
      if (!full_grp && 3'(i) >= fill_d) begin
        grp_now[i] = '0;
      end
      job_o.bits[b32d_pkg::GroupBits-1-b32d_pkg::SymW*i -: b32d_pkg::SymW] = grp_now[i];
    end
    job_o.count  = n_out;
    job_o.last   = in_data_i.end_of_string;
    job_o.status = err_d;
  end

  assign push_o = accept && (n_out != 3'd0 || in_data_i.end_of_string);

  // stale slots are never read: full groups overwrite all, tails mask past fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < b32d_pkg::GroupLen; i++) sym_q[i] <= '0;
    end else if (accept && wr_sym) begin
      sym_q[fill_q] <= sv_res[b32d_pkg::SymW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      pad_q   <= 1'b0;
      err_q   <= b32d_pkg::StatusOk;
      bytes_q <= '0;
    end else if (accept) begin
      if (in_data_i.end_of_string) begin
        fill_q  <= '0;
        pad_q   <= 1'b0;
        err_q   <= b32d_pkg::StatusOk;
        bytes_q <= '0;
      end else begin
        fill_q  <= fill_d;
        pad_q   <= pad_d;
        err_q   <= err_d;
        bytes_q <= bytes_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= b32d_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== sv/b32d_fifo.sv =====
module b32d_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b32d_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output b32d_pkg::job_t job_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = $clog2(b32d_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(b32d_pkg::QueueDepth + 1);

  b32d_pkg::job_t mem_q [b32d_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(b32d_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(b32d_pkg::QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== sv/b32d_back.sv =====
module b32d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  b32d_pkg::job_t job_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output b32d_pkg::out_t out_data_o
);

  logic [2:0]     idx_q;
  logic           out_valid_q;
  b32d_pkg::out_t out_q;
  b32d_pkg::out_t res;
  logic           load, last_elem;
  logic [7:0]     sel_byte;

  always_comb begin
    case (idx_q)
      3'd0:    sel_byte = job_i.bits[39:32];
      3'd1:    sel_byte = job_i.bits[31:24];
      3'd2:    sel_byte = job_i.bits[23:16];
      3'd3:    sel_byte = job_i.bits[15:8];
      3'd4:    sel_byte = job_i.bits[7:0];
      default: sel_byte = 8'd0;
    endcase
  end

  assign last_elem = (job_i.count == 3'd0) || (idx_q == job_i.count - 3'd1);
  assign load      = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o     = load && last_elem;

  always_comb begin
    if (job_i.count == 3'd0) begin
      // end of string with nothing left to emit: status only
      res.data_byte  = 8'd0;
      res.byte_valid = 1'b0;
      res.last       = 1'b1;
      res.status     = job_i.status;
    end else begin
      res.data_byte  = sel_byte;
      res.byte_valid = 1'b1;
      res.last       = job_i.last && last_elem;
      res.status     = res.last ? job_i.status : b32d_pkg::StatusOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= last_elem ? 3'd0 : idx_q + 3'd1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/b32d_checker.sv =====
module b32d_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input b32d_pkg::out_t out_data_o
);

  // a pending result is not withdrawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item dropped or changed while stalled");

  // an item without a byte only ever closes a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.last && out_data_o.data_byte == 8'd0)
    else $error("empty output item that is not last");

  // status is only reported on the closing item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.status == b32d_pkg::StatusOk)
    else $error("status on an item that is not last");

  // a byte is never delivered together with an error status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_valid |-> out_data_o.status == b32d_pkg::StatusOk)
    else $error("decoded byte carries an error status");

endmodule

bind base32_decoder b32d_checker u_b32d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== bench/base32_decoder_test.sv =====
module base32_decoder_test;

  // receiver stall patterns
  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoin,
    ReadySparse,
    ReadyBursty
  } ready_mode_e;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [b32d_pkg::LimitW-1:0] cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  b32d_pkg::in_t   in_item = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  b32d_pkg::out_t  out_item;

  // stimulus side
  b32d_pkg::in_t   char_q[$];
  int              chars_queued = 0;
  int              chars_taken = 0;
  logic            char_taken = 1'b0;
  int              burst_left = 1;
  int              gap_left = 0;

  // receiver side
  ready_mode_e     ready_mode = ReadyAlways;
  int              mode_left = 0;
  int              rx_tick = 0;

  // decoder image kept by the bench
  logic [b32d_pkg::LimitW-1:0] byte_limit = b32d_pkg::LimitReset;
  logic [4:0]      sym_buf[8];
  logic [2:0]      fill = '0;
  logic            pad_seen = 1'b0;
  b32d_pkg::status_e str_err = b32d_pkg::StatusOk;
  logic [b32d_pkg::LimitW-1:0] bytes_done = '0;
  b32d_pkg::out_t  decoded_q[$];
  int              mismatches = 0;

  base32_decoder u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // {not in alphabet, symbol value}
  function automatic logic [5:0] alpha_value(input logic [15:0] c);
    logic [15:0] d;
    d = 16'd0;
    if (c >= 16'h0041 && c <= 16'h005A) begin
      d = c - 16'h0041;
    end else if (c >= 16'h0061 && c <= 16'h007A) begin
      d = c - 16'h0061;
    end else if (c >= 16'h0032 && c <= 16'h0037) begin
      d = c - 16'h0032 + 16'd26;
    end else begin
      return 6'b100000;
    end
    return {1'b0, d[4:0]};
  endfunction

  function automatic logic [15:0] rand_symbol();
    int r;
    r = $urandom_range(0, 31);
    if (r >= 26) return 16'(16'h0032 + r - 26);
    if ($urandom_range(0, 1) == 1) return 16'(16'h0061 + r);
    return 16'(16'h0041 + r);
  endfunction

  // expected result items for one accepted character item
  task automatic decode_char(input b32d_pkg::in_t it);
    logic [5:0]     av;
    logic [39:0]    bits;
    logic [7:0]     bytes[5];
    int             nb;
    int             n;
    int             k;
    b32d_pkg::out_t r;
    nb = 0;
    n = 0;
    if (str_err == b32d_pkg::StatusOk) begin
      if (it.char_code == b32d_pkg::PadChar) begin
        pad_seen = 1'b1;
      end else if (pad_seen) begin
        str_err = b32d_pkg::StatusBadChar;
      end else begin
        av = alpha_value(it.char_code);
        if (av[5]) begin
          str_err = b32d_pkg::StatusBadChar;
        end else begin
          sym_buf[fill] = av[4:0];
          if (fill == 3'd7) begin
            fill = '0;
            if (int'(bytes_done) + 5 > int'(byte_limit)) begin
              str_err = b32d_pkg::StatusLimit;
            end else begin
              nb = 5;
              bytes_done = bytes_done + 10'd5;
            end
          end else begin
            fill = fill + 3'd1;
          end
        end
      end
    end
    // tail group at string end: leftover symbols are zero filled
    if (it.end_of_string && str_err == b32d_pkg::StatusOk && fill != 3'd0) begin
      case (fill)
        3'd2: n = 1;
        3'd4: n = 2;
        3'd5: n = 3;
        3'd7: n = 4;
        default: n = 0;
      endcase
      if (n != 0) begin
        if (int'(bytes_done) + n > int'(byte_limit)) begin
          str_err = b32d_pkg::StatusLimit;
        end else begin
          for (k = int'(fill); k < 8; k++) sym_buf[k] = '0;
          nb = n;
          bytes_done = bytes_done + b32d_pkg::LimitW'(n);
        end
      end
    end
    bits = {sym_buf[0], sym_buf[1], sym_buf[2], sym_buf[3],
            sym_buf[4], sym_buf[5], sym_buf[6], sym_buf[7]};
    for (k = 0; k < 5; k++) bytes[k] = bits[39 - 8 * k -: 8];
    for (k = 0; k < nb; k++) begin
      r.data_byte  = bytes[k];
      r.byte_valid = 1'b1;
      r.last       = it.end_of_string && (k == nb - 1);
      r.status     = r.last ? str_err : b32d_pkg::StatusOk;
      decoded_q.push_back(r);
    end
    // string end with no byte: a bare status item
    if (it.end_of_string && nb == 0) begin
      r.data_byte  = '0;
      r.byte_valid = 1'b0;
      r.last       = 1'b1;
      r.status     = str_err;
      decoded_q.push_back(r);
    end
    if (it.end_of_string) begin
      for (k = 0; k < 8; k++) sym_buf[k] = '0;
      fill = '0;
      pad_seen = 1'b0;
      str_err = b32d_pkg::StatusOk;
      bytes_done = '0;
    end
  endtask

  // driver: bursts of items from char_q with random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || char_taken) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (char_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_item  <= char_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stalls: pattern switches every so often
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (mode_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 150);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      ReadyAlways: out_ready <= 1'b1;
      ReadyCoin:   out_ready <= 1'($urandom_range(0, 1));
      ReadySparse: out_ready <= (rx_tick % 5 == 0);
      default:     out_ready <= (rx_tick % 16 >= 12);
    endcase
  end

  // monitor: check results first, then predict from the accepted item
  always @(posedge clk) begin : mon
    b32d_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("result item with nothing expected: %h", out_item);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_item.data_byte !== want.data_byte) begin
            $error("data_byte expected %0h got %0h", want.data_byte, out_item.data_byte);
            mismatches++;
          end
          if (out_item.byte_valid !== want.byte_valid) begin
            $error("byte_valid expected %0b got %0b", want.byte_valid, out_item.byte_valid);
            mismatches++;
          end
          if (out_item.last !== want.last) begin
            $error("last expected %0b got %0b", want.last, out_item.last);
            mismatches++;
          end
          if (out_item.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_item.status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_char(in_item);
        chars_taken++;
        char_taken <= 1'b1;
      end else begin
        char_taken <= 1'b0;
      end
    end
  end

  task automatic push_char(input logic [15:0] c, input logic eos);
    b32d_pkg::in_t it;
    it.char_code = c;
    it.end_of_string = eos;
    char_q.push_back(it);
    chars_queued++;
  endtask

  task automatic push_text(input string s, input logic eos);
    int i;
    for (i = 0; i < s.len(); i++) push_char(16'(s[i]), eos && (i == s.len() - 1));
  endtask

  // one random string: mostly well formed, some noise, some broken padding
  task automatic push_random_string(input int max_syms);
    logic [15:0] txt[$];
    int          pick;
    int          len;
    int          i;
    logic [15:0] c;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(1, max_syms);
    for (i = 0; i < len; i++) begin
      if (pick < 10 && $urandom_range(0, 1) == 1) txt.push_back(16'($urandom_range(0, 65535)));
      else txt.push_back(rand_symbol());
    end
    if (pick >= 10 && pick < 18) begin
      // something other than padding after padding
      txt.push_back(b32d_pkg::PadChar);
      do c = ($urandom_range(0, 1) == 1) ? rand_symbol() : 16'($urandom_range(0, 65535));
      while (c == b32d_pkg::PadChar);
      txt.push_back(c);
      if ($urandom_range(0, 1) == 1) txt.push_back(rand_symbol());
    end else if (pick >= 18 && $urandom_range(0, 1) == 1) begin
      while (txt.size() % 8 != 0) txt.push_back(b32d_pkg::PadChar);
    end
    for (i = 0; i < txt.size(); i++) push_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic push_random_items(input int count, input int max_syms);
    int stop_at;
    stop_at = chars_queued + count;
    while (chars_queued < stop_at) push_random_string(max_syms);
  endtask

  // wait for all items taken and all results seen, then some slack
  task automatic settle(input int extra);
    while (chars_taken != chars_queued || decoded_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_limit(input logic [b32d_pkg::LimitW-1:0] v);
    settle(10);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    byte_limit = v;
  endtask

  initial begin : stim
    int k;
    for (k = 0; k < 8; k++) sym_buf[k] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // alphabet extremes, a full group, then a two-symbol tail
    push_text("Az27Za7A", 1'b0);
    push_text("2Z", 1'b1);
    // single symbol: no byte, bare status
    push_text("A", 1'b1);
    // five symbols with padding
    push_text("MZXW6=", 1'b1);
    // symbol after padding, then characters outside the alphabet
    push_text("=BC", 1'b1);
    push_char(16'h0000, 1'b1);
    push_char(16'hFFFF, 1'b1);
    push_char(16'h0080, 1'b1);
    // just outside the alphabet ranges
    push_text("@", 1'b1);
    push_text("[", 1'b1);
    push_text("{", 1'b1);
    push_text("1", 1'b1);

    // hold the sender mid-string until the decoder has drained
    push_text("MZXW6YTBOI", 1'b0);
    settle(0);
    push_text("======", 1'b1);
    push_random_items(20, 20);

    // limit of one: one byte allowed, any more fails
    write_limit(10'd1);
    push_text("AB", 1'b1);
    push_text("ABCD", 1'b1);
    push_text("ABCDEFGH", 1'b1);
    push_random_items(15, 10);

    write_limit(10'd1023);
    push_random_items(20, 40);

    // exactly one group fits
    write_limit(10'd5);
    push_random_items(20, 16);

    write_limit(b32d_pkg::LimitW'($urandom_range(1, 1023)));
    push_random_items(15, 24);

    // tails land right at the limit
    write_limit(10'd13);
    push_random_items(15, 24);

    settle(20);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("base32_decoder_test: clean");
    end else begin
      $display("base32_decoder_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("base32_decoder_test: errors");
    $finish;
  end

endmodule
